// ===== rtl/mhrb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and microcode ROM for the multi-touch report builder.
// No dependencies.
package mhrb_pkg;

	localparam int SLOT_COUNT = 10;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int REC_BYTES  = 14;
	localparam int BUF_BYTES  = 32;
	localparam int FILL_W     = $clog2(BUF_BYTES + 1);
	localparam int LEN_W      = $clog2(REC_BYTES + 1);
	localparam int STEP_W     = 2;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

	localparam logic [7:0] REPORT_ID    = 8'h01;
	localparam logic [7:0] CONTACT_FLAGS = 8'h07;

	localparam logic [1:0] OP_SET   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_CLRALL = 2'd2;
	localparam logic [1:0] OP_REPORT = 2'd3;

	localparam logic [1:0] PUSH_NONE = 2'd0;
	localparam logic [1:0] PUSH_ID   = 2'd1;
	localparam logic [1:0] PUSH_REC  = 2'd2;
	localparam logic [1:0] PUSH_TAIL = 2'd3;

	localparam logic [1:0] COND_ALWAYS    = 2'd0;
	localparam logic [1:0] COND_SLOT_END  = 2'd1;
	localparam logic [1:0] COND_DRAIN_END = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  slot;
		logic        active;
		logic [15:0] touch_id;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] touch_width;
		logic [15:0] touch_height;
		logic [7:0]  tip_pressure;
		logic [15:0] azimuth_angle;
	} hid_cmd_t;

	typedef struct packed {
		logic [31:0] report_word;
		logic [5:0]  word_index;
		logic        word_last;
	} hid_word_t;

	typedef struct packed {
		logic [15:0] touch_id;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] touch_width;
		logic [15:0] touch_height;
		logic [7:0]  tip_pressure;
		logic [15:0] azimuth_angle;
	} contact_t;

	typedef struct packed {
		logic              set;
		logic              clear;
		logic              clear_all;
		logic [SLOT_W-1:0] idx;
		contact_t          rec;
	} tbl_wr_t;

	typedef struct packed {
		logic                           push_en;
		logic                           drain;
		logic [LEN_W-1:0]               seg_len;
		logic [REC_BYTES-1:0][7:0]      seg;
	} pack_ctl_t;

	typedef struct packed {
		logic room;
		logic drain_end;
	} pack_sts_t;

	typedef struct packed {
		logic [1:0]        push;
		logic [1:0]        cond;
		logic              drain;
		logic [STEP_W-1:0] next;
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t uc;
		unique case (step)
			2'd0: uc = '{push: PUSH_ID,   cond: COND_ALWAYS,    drain: 1'b0, next: 2'd1};
			2'd1: uc = '{push: PUSH_REC,  cond: COND_SLOT_END,  drain: 1'b0, next: 2'd2};
			2'd2: uc = '{push: PUSH_TAIL, cond: COND_ALWAYS,    drain: 1'b0, next: 2'd3};
			2'd3: uc = '{push: PUSH_NONE, cond: COND_DRAIN_END, drain: 1'b1, next: 2'd0};
		endcase
		return uc;
	endfunction

endpackage

// ===== rtl/mhrb_slot_table.sv =====
`timescale 1ns / 1ps
// Contact slot table: per-slot active flags and contact payload registers.
// Depends on mhrb_pkg.
module mhrb_slot_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mhrb_pkg::tbl_wr_t         wr,
	input  logic [mhrb_pkg::SLOT_W-1:0] rd_slot,
	output mhrb_pkg::contact_t        rd_rec,
	output logic                      rd_active
);
	import mhrb_pkg::*;

	logic     active_q [SLOT_COUNT];
	contact_t rec_q    [SLOT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) active_q[i] <= 1'b0;
		end else if (wr.clear_all) begin
			for (int i = 0; i < SLOT_COUNT; i++) active_q[i] <= 1'b0;
		end else if (wr.set) begin
			active_q[wr.idx] <= 1'b1;
		end else if (wr.clear) begin
			active_q[wr.idx] <= 1'b0;
		end
	end

	// payload is only read while the slot is active
	always_ff @(posedge clk) begin
		if (wr.set) begin
			rec_q[wr.idx] <= wr.rec;
		end
	end

	assign rd_rec    = rec_q[rd_slot];
	assign rd_active = active_q[rd_slot];

endmodule

// ===== rtl/mhrb_seq.sv =====
`timescale 1ns / 1ps
// Microcoded report sequencer: step counter, ROM decode, slot walk, count and scan time.
// Depends on mhrb_pkg.
module mhrb_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  mhrb_pkg::contact_t          rec,
	input  logic                        rec_active,
	input  mhrb_pkg::pack_sts_t         sts,
	output logic                        busy,
	output logic [mhrb_pkg::SLOT_W-1:0] rd_slot,
	output mhrb_pkg::pack_ctl_t         ctl
);
	import mhrb_pkg::*;

	logic              run_q;
	logic [STEP_W-1:0] step_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [15:0]       scan_q;
	ucode_t            uc;
	logic              advance;

	assign uc = ucode_rom(step_q);

	always_comb begin
		ctl.push_en = run_q && (uc.push != PUSH_NONE);
		ctl.drain   = run_q && uc.drain;
		ctl.seg     = '0;
		ctl.seg_len = '0;
		case (uc.push)
			PUSH_ID: begin
				ctl.seg[0]  = REPORT_ID;
				ctl.seg_len = LEN_W'(1);
			end
			PUSH_REC: begin
				ctl.seg_len = LEN_W'(REC_BYTES);
				if (rec_active) begin
					ctl.seg = {rec.azimuth_angle, rec.tip_pressure, rec.touch_height,
						rec.touch_width, rec.pos_y, rec.pos_x, rec.touch_id,
						CONTACT_FLAGS};
				end
			end
			PUSH_TAIL: begin
				ctl.seg[0]  = 8'(count_q);
				ctl.seg[1]  = scan_q[7:0];
				ctl.seg[2]  = scan_q[15:8];
				ctl.seg_len = LEN_W'(3);
			end
			default: ;
		endcase
	end

	assign advance = !ctl.push_en || sts.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			step_q  <= '0;
			slot_q  <= '0;
			count_q <= '0;
			scan_q  <= '0;
		end else if (go) begin
			run_q   <= 1'b1;
			step_q  <= '0;
			slot_q  <= '0;
			count_q <= '0;
		end else if (run_q && advance) begin
			if (uc.push == PUSH_REC && rec_active) begin
				count_q <= count_q + CNT_W'(1);
			end
			case (uc.cond)
				COND_ALWAYS: step_q <= uc.next;
				COND_SLOT_END: begin
					if (slot_q == SLOT_LAST) begin
						step_q <= uc.next;
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
					end
				end
				COND_DRAIN_END: begin
					if (sts.drain_end) begin
						run_q  <= 1'b0;
						step_q <= uc.next;
						scan_q <= scan_q + 16'd1;
					end
				end
				default: ;
			endcase
		end
	end

	assign busy    = run_q;
	assign rd_slot = slot_q;

endmodule

// ===== rtl/mhrb_packer.sv =====
`timescale 1ns / 1ps
// Byte stream packer: 32-byte buffer, segment insert, one 32-bit word out per transfer.
// Depends on mhrb_pkg.
module mhrb_packer (
	input  logic                clk,
	input  logic                arst_n,
	input  mhrb_pkg::pack_ctl_t ctl,
	output mhrb_pkg::pack_sts_t sts,
	output logic                word_valid,
	output mhrb_pkg::hid_word_t word
);
	import mhrb_pkg::*;

	logic [7:0]        buf_q [BUF_BYTES];
	logic [7:0]        buf_d [BUF_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_nx;
	logic [5:0]        widx_q;
	logic              pop;
	logic              push;
	logic [FILL_W:0]   need;

	assign pop     = (fill_q >= FILL_W'(4)) || (ctl.drain && fill_q != '0);
	assign fill_nx = !pop ? fill_q : (fill_q >= FILL_W'(4)) ? fill_q - FILL_W'(4) : '0;
	assign need    = {1'b0, fill_nx} + (FILL_W+1)'(ctl.seg_len);
	assign sts.room      = need <= (FILL_W+1)'(BUF_BYTES);
	assign sts.drain_end = ctl.drain && fill_q != '0 && fill_q <= FILL_W'(4);
	assign push    = ctl.push_en && sts.room;

	always_comb begin
		logic [FILL_W:0] off;
		for (int i = 0; i < BUF_BYTES - 4; i++) begin
			buf_d[i] = pop ? buf_q[i + 4] : buf_q[i];
		end
		for (int i = BUF_BYTES - 4; i < BUF_BYTES; i++) begin
			buf_d[i] = pop ? 8'h00 : buf_q[i];
		end
		for (int i = 0; i < BUF_BYTES; i++) begin
			off = (FILL_W+1)'(i) - {1'b0, fill_nx};
			if (push && (FILL_W+1)'(i) >= {1'b0, fill_nx}
				&& off < (FILL_W+1)'(ctl.seg_len)) begin
				buf_d[i] = ctl.seg[off[LEN_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < BUF_BYTES; i++) buf_q[i] <= buf_d[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			widx_q <= '0;
		end else begin
			fill_q <= push ? need[FILL_W-1:0] : fill_nx;
			if (sts.drain_end) begin
				widx_q <= '0;
			end else if (pop) begin
				widx_q <= widx_q + 6'd1;
			end
		end
	end

	// bytes past the fill level are padding
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			word.report_word[8*k +: 8] = (FILL_W'(k) < fill_q) ? buf_q[k] : 8'h00;
		end
		word.word_index = widx_q;
		word.word_last  = sts.drain_end;
	end

	assign word_valid = pop;

endmodule

// ===== rtl/multitouch_hid_report_builder.sv =====
`timescale 1ns / 1ps
// Multi-touch digitizer report builder top level. Table ops (set, clear, clear all)
// finish at the accepting edge; busy stays low. A report request holds busy while
// 36 words go out on consecutive cycles, once the report ID and the first record are
// buffered; the next command is taken only after busy falls with the last word.
// Results cannot be stalled. arst_n clears all slots, the scan time and the sequencer.
module multitouch_hid_report_builder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mhrb_pkg::hid_cmd_t  command,
	output logic                result_strobe,
	output mhrb_pkg::hid_word_t result
);
	import mhrb_pkg::*;

	logic              accept;
	logic              in_range;
	tbl_wr_t           wr;
	logic [SLOT_W-1:0] rd_slot;
	contact_t          rd_rec;
	logic              rd_active;
	pack_ctl_t         ctl;
	pack_sts_t         sts;

	assign accept   = start && !busy;
	assign in_range = {1'b0, command.slot} < 5'(SLOT_COUNT);

	always_comb begin
		wr.set       = accept && in_range && command.operation == OP_SET && command.active;
		wr.clear     = accept && in_range && (command.operation == OP_CLEAR
			|| (command.operation == OP_SET && !command.active));
		wr.clear_all = accept && command.operation == OP_CLRALL;
		wr.idx       = command.slot[SLOT_W-1:0];
		wr.rec       = '{touch_id:     command.touch_id,
		                 pos_x:        command.pos_x,
		                 pos_y:        command.pos_y,
		                 touch_width:  command.touch_width,
		                 touch_height: command.touch_height,
		                 tip_pressure: command.tip_pressure,
		                 azimuth_angle: command.azimuth_angle};
	end

	mhrb_slot_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd_slot   (rd_slot),
		.rd_rec    (rd_rec),
		.rd_active (rd_active)
	);

	mhrb_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (accept && command.operation == OP_REPORT),
		.rec        (rd_rec),
		.rec_active (rd_active),
		.sts        (sts),
		.busy       (busy),
		.rd_slot    (rd_slot),
		.ctl        (ctl)
	);

	mhrb_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.word_valid (result_strobe),
		.word       (result)
	);

endmodule

// ===== rtl/mhrb_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the report builder, bound to the top level.
// Depends on mhrb_pkg and multitouch_hid_report_builder.
module mhrb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input mhrb_pkg::hid_cmd_t  command,
	input logic                result_strobe,
	input mhrb_pkg::hid_word_t result
);
	import mhrb_pkg::*;

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result transfer while idle");

	a_table_op_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command.operation != OP_REPORT) |=> !busy)
		else $error("table operation raised busy");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.word_last) |=> !busy)
		else $error("busy after last word");

	a_not_last_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.word_last) |=> busy)
		else $error("report ended without last word");

	a_fall_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(result_strobe && result.word_last))
		else $error("busy fell without last word");

endmodule

bind multitouch_hid_report_builder mhrb_checker u_mhrb_checker (.*);
